// ===== rtl/sfp_pkg.sv =====
// ============================================================================
// sfp_pkg
// Shared types and constants of the four-point sphere solver.
// ============================================================================
`default_nettype none

package sfp_pkg;

    localparam int CoordW = 20;
    localparam int CfgW   = 40;
    localparam int OutW   = 32;
    localparam int MagW   = 83;
    localparam int DvW    = 65;
    localparam int QW     = 33;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_COPLANAR = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [CoordW-1:0] ax;
        logic signed [CoordW-1:0] ay;
        logic signed [CoordW-1:0] az;
        logic signed [CoordW-1:0] bx;
        logic signed [CoordW-1:0] by;
        logic signed [CoordW-1:0] bz;
        logic signed [CoordW-1:0] cx;
        logic signed [CoordW-1:0] cy;
        logic signed [CoordW-1:0] cz;
        logic signed [CoordW-1:0] dx;
        logic signed [CoordW-1:0] dy;
        logic signed [CoordW-1:0] dz;
    } t_in_word;

    typedef struct packed {
        logic signed [OutW-1:0] center_x;
        logic signed [OutW-1:0] center_y;
        logic signed [OutW-1:0] center_z;
        logic [OutW-1:0]        sphere_radius;
        logic [1:0]             status;
    } t_out_word;

    // numerator magnitudes, divisor and flags handed to the divider
    typedef struct packed {
        logic [2:0][MagW-1:0]   mag;
        logic [2:0]             neg;
        logic [2:0]             big;
        logic [DvW-1:0]         dv;
        logic                   copl;
        logic [2:0][CoordW-1:0] pa;
    } t_div_word;

    // clamped center handed to the radius unit
    typedef struct packed {
        logic [2:0][OutW-1:0]   ctr;
        logic                   sat;
        logic                   copl;
        logic [2:0][CoordW-1:0] pa;
    } t_ctr_word;

endpackage

`default_nettype wire

// ===== rtl/sfp_geom.sv =====
// ============================================================================
// sfp_geom
// Differences, squared norms, cross products, volume and center numerators,
// seven register stages.
// ============================================================================
`default_nettype none

module sfp_geom
    import sfp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_in_word        i_word,
    input  logic [CfgW-1:0] i_min_vol,
    output logic            o_valid,
    output t_div_word       o_word
);

    localparam int DiffW = 21;
    localparam int SqW   = 40;
    localparam int SumW  = 42;
    localparam int EW    = 41;
    localparam int XW    = 43;
    localparam int XLoW  = 22;
    localparam int VpW   = 64;
    localparam int PlW   = 64;
    localparam int PhW   = 62;
    localparam int VolW  = 66;
    localparam int AccW  = 84;
    localparam int VmW   = 64;
    localparam int BigW  = DvW + QW;
    localparam int Depth = 7;

    logic signed [CoordW-1:0] w_p [4][3];
    logic [Depth-1:0]         r_v;

    logic signed [DiffW-1:0]  r1_d [3][3], n1_d [3][3];
    logic [SqW-1:0]           r1_sq [4][3], n1_sq [4][3];
    logic signed [CoordW-1:0] r1_a [3];

    logic [SumW-1:0]          w_s [4];
    logic signed [EW-1:0]     r2_e [3], n2_e [3];
    logic signed [XW-1:0]     r2_x [3][3], n2_x [3][3];
    logic signed [DiffW-1:0]  r2_d0 [3];
    logic signed [CoordW-1:0] r2_a [3];

    logic signed [VpW-1:0]    r3_vp [3], n3_vp [3];
    logic signed [PlW-1:0]    r3_pl [3][3], n3_pl [3][3];
    logic signed [PhW-1:0]    r3_ph [3][3], n3_ph [3][3];
    logic signed [CoordW-1:0] r3_a [3];

    logic signed [VolW-1:0]   r4_vol, n4_vol;
    logic signed [AccW-1:0]   r4_t [3][3], n4_t [3][3];
    logic signed [CoordW-1:0] r4_a [3];

    logic signed [AccW-1:0]   r5_acc [3], n5_acc [3];
    logic                     r5_vneg;
    logic [VmW-1:0]           r5_vmag, n5_vmag;
    logic signed [CoordW-1:0] r5_a [3];

    logic [MagW-1:0]          r6_mag [3], n6_mag [3];
    logic [2:0]               r6_neg, n6_neg;
    logic [DvW-1:0]           r6_dv;
    logic                     r6_copl, n6_copl;
    logic signed [CoordW-1:0] r6_a [3];

    t_div_word                r_w, n_w;

    always_comb begin
        w_p[0][0] = i_word.ax; w_p[0][1] = i_word.ay; w_p[0][2] = i_word.az;
        w_p[1][0] = i_word.bx; w_p[1][1] = i_word.by; w_p[1][2] = i_word.bz;
        w_p[2][0] = i_word.cx; w_p[2][1] = i_word.cy; w_p[2][2] = i_word.cz;
        w_p[3][0] = i_word.dx; w_p[3][1] = i_word.dy; w_p[3][2] = i_word.dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Depth-2:0], i_valid};
        end
    end

    // stage 1: differences and coordinate squares
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                n1_d[k][j] = DiffW'(w_p[k+1][j]) - DiffW'(w_p[0][j]);
            end
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 3; j++) begin
                n1_sq[i][j] = SqW'(w_p[i][j]) * SqW'(w_p[i][j]);
            end
        end
    end

    // stage 2: norm differences and cross products
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_s[i] = SumW'(r1_sq[i][0]) + SumW'(r1_sq[i][1]) + SumW'(r1_sq[i][2]);
        end
        for (int k = 0; k < 3; k++) begin
            n2_e[k] = EW'(w_s[k+1] - w_s[0]);
        end
        for (int t = 0; t < 3; t++) begin
            for (int j = 0; j < 3; j++) begin
                n2_x[t][j] = XW'(r1_d[(t+1)%3][(j+1)%3]) * XW'(r1_d[(t+2)%3][(j+2)%3])
                           - XW'(r1_d[(t+1)%3][(j+2)%3]) * XW'(r1_d[(t+2)%3][(j+1)%3]);
            end
        end
    end

    // stage 3: volume terms and split numerator products
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n3_vp[j] = VpW'(r2_d0[j]) * VpW'(r2_x[0][j]);
            for (int i = 0; i < 3; i++) begin
                n3_pl[j][i] = PlW'(r2_e[i]) * PlW'($signed({1'b0, r2_x[i][j][XLoW-1:0]}));
                n3_ph[j][i] = PhW'(r2_e[i]) * PhW'($signed(r2_x[i][j][XW-1:XLoW]));
            end
        end
    end

    // stage 4: volume sum and product recombination
    always_comb begin
        n4_vol = VolW'(r3_vp[0]) + VolW'(r3_vp[1]) + VolW'(r3_vp[2]);
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                n4_t[j][i] = AccW'(r3_pl[j][i]) + (AccW'(r3_ph[j][i]) <<< XLoW);
            end
        end
    end

    // stage 5: numerator sums and volume magnitude
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n5_acc[j] = r4_t[j][0] + r4_t[j][1] + r4_t[j][2];
        end
        n5_vmag = VmW'(r4_vol[VolW-1] ? -r4_vol : r4_vol);
    end

    // stage 6: numerator magnitudes, result signs, coplanar test
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n6_mag[j] = MagW'(r5_acc[j][AccW-1] ? -r5_acc[j] : r5_acc[j]);
            n6_neg[j] = r5_acc[j][AccW-1] ^ r5_vneg;
        end
        n6_copl = (r5_vmag == '0) || (r5_vmag < VmW'(i_min_vol));
    end

    // stage 7: quotient range check
    always_comb begin
        n_w.neg  = r6_neg;
        n_w.dv   = r6_dv;
        n_w.copl = r6_copl;
        for (int j = 0; j < 3; j++) begin
            n_w.mag[j] = r6_mag[j];
            n_w.pa[j]  = r6_a[j];
            n_w.big[j] = BigW'(r6_mag[j]) >= {r6_dv, QW'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d    <= n1_d;
            r1_sq   <= n1_sq;
            r1_a    <= '{w_p[0][0], w_p[0][1], w_p[0][2]};
            r2_e    <= n2_e;
            r2_x    <= n2_x;
            r2_d0   <= r1_d[0];
            r2_a    <= r1_a;
            r3_vp   <= n3_vp;
            r3_pl   <= n3_pl;
            r3_ph   <= n3_ph;
            r3_a    <= r2_a;
            r4_vol  <= n4_vol;
            r4_t    <= n4_t;
            r4_a    <= r3_a;
            r5_acc  <= n5_acc;
            r5_vneg <= r4_vol[VolW-1];
            r5_vmag <= n5_vmag;
            r5_a    <= r4_a;
            r6_mag  <= n6_mag;
            r6_neg  <= n6_neg;
            r6_dv   <= {r5_vmag, 1'b0};
            r6_copl <= n6_copl;
            r6_a    <= r5_a;
            r_w     <= n_w;
        end
    end

    assign o_valid = r_v[Depth-1];
    assign o_word  = r_w;

endmodule

`default_nettype wire

// ===== rtl/sfp_div.sv =====
// ============================================================================
// sfp_div
// Three-lane pipelined restoring divider, one quotient bit per stage, with
// round to nearest and clamping to the signed 32-bit range.
// ============================================================================
`default_nettype none

module sfp_div
    import sfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_div_word i_word,
    output logic      o_valid,
    output t_ctr_word o_word
);

    localparam int RemW  = DvW;
    localparam int Steps = QW;
    localparam logic [QW:0] LimPos = (QW+1)'(32'h7FFF_FFFF);
    localparam logic [QW:0] LimNeg = (QW+1)'(32'h8000_0000);

    typedef struct packed {
        logic [2:0][RemW-1:0]   rem;
        logic [2:0][QW-1:0]     low;
        logic [2:0][QW-1:0]     q;
        logic [DvW-1:0]         dv;
        logic [2:0]             neg;
        logic [2:0]             big;
        logic                   copl;
        logic [2:0][CoordW-1:0] pa;
    } t_dst;

    function automatic t_dst div_step(t_dst x);
        t_dst         y;
        logic [RemW:0] sh;
        y = x;
        for (int j = 0; j < 3; j++) begin
            sh = {x.rem[j], x.low[j][QW-1]};
            if (sh >= {1'b0, x.dv}) begin
                sh      = sh - {1'b0, x.dv};
                y.q[j]  = {x.q[j][QW-2:0], 1'b1};
            end else begin
                y.q[j]  = {x.q[j][QW-2:0], 1'b0};
            end
            y.rem[j] = sh[RemW-1:0];
            y.low[j] = {x.low[j][QW-2:0], 1'b0};
        end
        return y;
    endfunction

    t_dst             w_init;
    t_dst             w_src [Steps];
    t_dst             r_st [Steps];
    logic [Steps:0]   r_v;
    t_ctr_word        r_out, n_out;
    logic [RemW+1:0]  w_twice [3];
    logic [QW:0]      w_qr [3];
    logic [QW:0]      w_lim [3];
    logic [QW:0]      w_mag [3];
    logic [2:0]       w_sat;

    always_comb begin
        w_init      = '0;
        w_init.dv   = i_word.dv;
        w_init.neg  = i_word.neg;
        w_init.big  = i_word.big;
        w_init.copl = i_word.copl;
        w_init.pa   = i_word.pa;
        for (int j = 0; j < 3; j++) begin
            w_init.rem[j] = RemW'(i_word.mag[j][MagW-1:QW]);
            w_init.low[j] = i_word.mag[j][QW-1:0];
        end
    end

    assign w_src[0] = w_init;

    for (genvar s = 0; s < Steps; s++) begin : g_step
        if (s > 0) begin : g_link
            assign w_src[s] = r_st[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= div_step(w_src[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Steps-1:0], i_valid};
        end
    end

    // rounding and clamping
    always_comb begin
        n_out.copl = r_st[Steps-1].copl;
        n_out.pa   = r_st[Steps-1].pa;
        for (int j = 0; j < 3; j++) begin
            w_twice[j] = {1'b0, r_st[Steps-1].rem[j], 1'b0};
            w_qr[j]    = {1'b0, r_st[Steps-1].q[j]}
                       + (QW+1)'(w_twice[j] >= {2'b00, r_st[Steps-1].dv});
            w_lim[j]   = r_st[Steps-1].neg[j] ? LimNeg : LimPos;
            w_sat[j]   = r_st[Steps-1].big[j] || (w_qr[j] > w_lim[j]);
            w_mag[j]   = w_sat[j] ? w_lim[j] : w_qr[j];
            n_out.ctr[j] = r_st[Steps-1].neg[j] ? OutW'(-w_mag[j]) : OutW'(w_mag[j]);
        end
        n_out.sat = |w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[Steps];
    assign o_word  = r_out;

endmodule

`default_nettype wire

// ===== rtl/sfp_rad.sv =====
// ============================================================================
// sfp_rad
// Squared distance from the first point to the center and a pipelined
// rounded square root, two radicand bits per stage; forms the output word.
// ============================================================================
`default_nettype none

module sfp_rad
    import sfp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_ctr_word i_word,
    output logic      o_valid,
    output t_out_word o_word
);

    localparam int DW    = OutW + 2;
    localparam int SqW   = 2 * OutW;
    localparam int SumW  = SqW + 2;
    localparam int Steps = SqW / 2;
    localparam int Depth = Steps + 4;

    typedef struct packed {
        logic [SqW-1:0]       x;
        logic [SqW-1:0]       res;
        logic                 ovf;
        logic                 sat;
        logic                 copl;
        logic [2:0][OutW-1:0] ctr;
    } t_sst;

    function automatic t_sst sqrt_step(t_sst a, logic [SqW-1:0] one);
        t_sst b;
        b = a;
        if (a.x >= a.res + one) begin
            b.x   = a.x - (a.res + one);
            b.res = (a.res >> 1) + one;
        end else begin
            b.res = a.res >> 1;
        end
        return b;
    endfunction

    logic [Depth-1:0]     r_v;
    logic signed [DW-1:0] w_diff [3];
    logic [OutW-1:0]      rA_m [3], nA_m [3];
    t_ctr_word            rA_w;
    logic [SqW-1:0]       rB_sq [3];
    t_ctr_word            rB_w;
    logic [SumW-1:0]      w_sum;
    t_sst                 w_c;
    t_sst                 r_c;
    t_sst                 w_src [Steps];
    t_sst                 r_st [Steps];
    logic [OutW:0]        w_rr;
    logic                 w_rsat;
    t_out_word            r_out, n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[Depth-2:0], i_valid};
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_diff[j] = DW'($signed(i_word.pa[j])) - DW'($signed(i_word.ctr[j]));
            nA_m[j]   = OutW'(w_diff[j][DW-1] ? -w_diff[j] : w_diff[j]);
        end
    end

    always_comb begin
        w_sum      = SumW'(rB_sq[0]) + SumW'(rB_sq[1]) + SumW'(rB_sq[2]);
        w_c.x      = w_sum[SqW-1:0];
        w_c.res    = '0;
        w_c.ovf    = w_sum[SumW-1:SqW] != '0;
        w_c.sat    = rB_w.sat;
        w_c.copl   = rB_w.copl;
        w_c.ctr    = rB_w.ctr;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            rA_m <= nA_m;
            rA_w <= i_word;
            for (int j = 0; j < 3; j++) begin
                rB_sq[j] <= SqW'(rA_m[j]) * SqW'(rA_m[j]);
            end
            rB_w <= rA_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= w_c;
        end
    end

    assign w_src[0] = r_c;

    for (genvar s = 0; s < Steps; s++) begin : g_step
        if (s > 0) begin : g_link
            assign w_src[s] = r_st[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= sqrt_step(w_src[s], SqW'(1) << (SqW - 2 - 2 * s));
            end
        end
    end

    // rounding, saturation and status
    always_comb begin
        w_rr   = (OutW+1)'(r_st[Steps-1].res)
               + (OutW+1)'(r_st[Steps-1].x > r_st[Steps-1].res);
        w_rsat = r_st[Steps-1].ovf || w_rr[OutW];
        if (r_st[Steps-1].copl) begin
            n_out = '0;
            n_out.status = ST_COPLANAR;
        end else begin
            n_out.center_x      = r_st[Steps-1].ctr[0];
            n_out.center_y      = r_st[Steps-1].ctr[1];
            n_out.center_z      = r_st[Steps-1].ctr[2];
            n_out.sphere_radius = w_rsat ? '1 : w_rr[OutW-1:0];
            n_out.status        = (w_rsat || r_st[Steps-1].sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[Depth-1];
    assign o_word  = r_out;

endmodule

`default_nettype wire

// ===== rtl/sphere_from_four_points.sv =====
// ============================================================================
// sphere_from_four_points
// Circumsphere of four Q10.10 points: center and radius in Q22.10 with status.
// ============================================================================
// One word of four points is taken every clock cycle unless o_stall is high.
// Its result passes through seven stages of products and sums, 33 stages of
// the center divider (one quotient bit each) plus a rounding stage, 36 stages
// for the distance, the square root (two radicand bits each) and status, and
// the output register. The units before it move on one enable that drops
// only while a result stalls at the output and the last stage is full.
// ============================================================================
`default_nettype none

module sphere_from_four_points
    import sfp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_in_word        i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output t_out_word       o_data,
    input  logic            i_cfg_we,
    input  logic [CfgW-1:0] i_cfg_wdata
);

    logic [CfgW-1:0] r_min_vol;
    logic            w_load;
    logic            w_adv;
    logic            w_geom_v;
    t_div_word       w_geom_w;
    logic            w_div_v;
    t_ctr_word       w_div_w;
    logic            w_rad_v;
    t_out_word       w_rad_w;
    logic            r_out_valid;
    t_out_word       r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_vol <= CfgW'(1);
        end else if (i_cfg_we) begin
            r_min_vol <= i_cfg_wdata;
        end
    end

    assign w_load  = !r_out_valid || !i_stall;
    assign w_adv   = w_load || !w_rad_v;
    assign o_stall = !w_adv;

    sfp_geom u_geom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_valid   (i_valid),
        .i_word    (i_data),
        .i_min_vol (r_min_vol),
        .o_valid   (w_geom_v),
        .o_word    (w_geom_w)
    );

    sfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_geom_v),
        .i_word  (w_geom_w),
        .o_valid (w_div_v),
        .o_word  (w_div_w)
    );

    sfp_rad u_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_div_v),
        .i_word  (w_div_w),
        .o_valid (w_rad_v),
        .o_word  (w_rad_w)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= w_rad_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_rad_w;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef ASSERT_OFF
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.status == ST_OK || o_data.status == ST_COPLANAR ||
                     o_data.status == ST_SAT))
        else $error("undefined status code");

    a_coplanar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_COPLANAR) |->
            (o_data.center_x == '0 && o_data.center_y == '0 &&
             o_data.center_z == '0 && o_data.sphere_radius == '0))
        else $error("coplanar word with nonzero fields");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && w_rad_v))
        else $error("input stalled without a blocked result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
